// ----- design/slu_pkg.sv -----
`default_nettype none

package slu_pkg;

   localparam int TOKEN_CAP   = 128;
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] TOKEN_LIMIT = 8'(TOKEN_CAP);

   // character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_BAR    = 8'h7C;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_QUOTE,
      MODE_ESCAPE,
      MODE_AMP,
      MODE_BAR,
      MODE_DIGIT
   } mode_type;

   typedef enum logic [1:0] {
      KIND_CHAR,
      KIND_END,
      KIND_OP,
      KIND_SCRIPT
   } kind_type;

   typedef enum logic [2:0] {
      OP_SEMI,
      OP_PIPE,
      OP_IN,
      OP_OUT,
      OP_AND,
      OP_OR,
      OP_FD_OUT
   } op_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  char_out;
      op_type      op;
      logic [3:0]  fd;
      logic [6:0]  index;
      logic        truncated;
   } result_type;

   // all results caused by one byte
   typedef struct packed {
      logic [1:0]                        count;
      result_type [MAX_RESULTS-1:0]      res;
   } run_type;

   typedef struct packed {
      mode_type    mode;
      logic        quote_dbl;
      logic [3:0]  digit;
      logic [6:0]  tok_total;
      logic        dropped;
   } lex_state_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic result_type make_result(
      input kind_type   kind,
      input logic [7:0] ch,
      input op_type     op,
      input logic [3:0] fd,
      input logic [6:0] index,
      input logic       tr
   );
      result_type r;
      r.kind      = kind;
      r.char_out  = ch;
      r.op        = op;
      r.fd        = fd;
      r.index     = index;
      r.truncated = tr;
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- design/slu_channels.sv -----
`default_nettype none

interface slu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface slu_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] char_out;
   logic [2:0] op_code;
   logic [3:0] redirect_fd;
   logic [6:0] token_index;
   logic       truncated;
   logic       last_of_run;

   modport source (output valid, output result_kind, output char_out, output op_code,
                   output redirect_fd, output token_index, output truncated,
                   output last_of_run, input ready);
   modport sink   (input valid, input result_kind, input char_out, input op_code,
                   input redirect_fd, input token_index, input truncated,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- design/shell_command_lexer_unit.sv -----
// Shell command-line lexer.
// req_bus (sink): one script byte per beat in char_in; byte 0 ends the script,
//   flushes any pending token, emits a script-end beat and returns the lexer
//   to its reset state.
// rsp_bus (source): result beats - word characters, word ends, operator
//   codes, script end. Each input byte causes zero to three beats; the last
//   beat of a byte carries last_of_run. A byte that causes none (whitespace,
//   quote marks, held lookahead) produces no beat.
// The run of an accepted byte is registered in the run queue; its first beat
//   is offered when that run heads the queue. Throughput: one byte per cycle
//   in while the queue is not full; one beat per cycle out while ready is high.
// A four-entry run queue sits between the lexer front end and the output
//   serializer; req ready depends only on that queue being full, so a stalled
//   receiver lets up to four result-producing bytes in before input stalls.
// Reset (synchronous, active high) clears lexer state, token count, queue
//   and serializer position; payload storage is not cleared.
`default_nettype none

module shell_command_lexer_unit (
   input  wire logic clock,
   input  wire logic reset,
   slu_req_if.sink   req_bus,
   slu_rsp_if.source rsp_bus
);

   logic             queue_full;
   logic             queue_empty;
   logic             push_valid;
   logic             pop;
   slu_pkg::run_type push_run;
   slu_pkg::run_type head_run;

   // lexer state machine: one byte per cycle while the run queue is not full, builds the run for that byte
   slu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .in_char    (req_bus.char_in),
      .queue_full (queue_full),
      .in_ready   (req_bus.ready),
      .push_valid (push_valid),
      .push_run   (push_run)
   );

   // decouples the lexer from output stalls
   slu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_run (push_run),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head_run (head_run)
   );

   // serializes each run into beats
   slu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!queue_empty),
      .head_run   (head_run),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

endmodule

`default_nettype wire

// ----- design/slu_front.sv -----
`default_nettype none

module slu_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [7:0]       in_char,
   input  wire logic             queue_full,
   output logic                  in_ready,
   output logic                  push_valid,
   output slu_pkg::run_type      push_run
);

   slu_pkg::lex_state_type state_ff, state_in;
   slu_pkg::lex_state_type st;
   slu_pkg::result_type    res [slu_pkg::MAX_RESULTS];
   logic [1:0]             n;
   logic                   run_word, run_idle, run_plain;
   logic                   accept;

   localparam slu_pkg::lex_state_type STATE_RESET = '{
      mode: slu_pkg::MODE_IDLE, quote_dbl: 1'b0, digit: 4'd0,
      tok_total: 7'd0, dropped: 1'b0};

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   // Walks the byte through the lexer steps; up to three results per byte.
   always_comb begin
      st        = state_ff;
      n         = 2'd0;
      run_word  = 1'b0;
      run_idle  = 1'b0;
      run_plain = 1'b0;
      for (int i = 0; i < slu_pkg::MAX_RESULTS; i++) begin
         res[i] = '0;
      end

      if (in_char == slu_pkg::CH_NUL) begin
         // flush whatever is pending, then close the script
         case (st.mode)
            slu_pkg::MODE_WORD, slu_pkg::MODE_QUOTE: begin
               res[n] = slu_pkg::make_result(slu_pkg::KIND_END, 8'd0, slu_pkg::OP_SEMI, 4'd0,
                                             st.tok_total, 1'b0);
               n = n + 2'd1;
               st.tok_total = st.tok_total + 7'd1;
            end
            slu_pkg::MODE_ESCAPE, slu_pkg::MODE_AMP, slu_pkg::MODE_DIGIT: begin
               res[n] = slu_pkg::make_result(slu_pkg::KIND_CHAR,
                  (st.mode == slu_pkg::MODE_ESCAPE) ? slu_pkg::CH_BSLASH :
                  (st.mode == slu_pkg::MODE_AMP) ? slu_pkg::CH_AMP :
                  (slu_pkg::CH_ZERO + {4'd0, st.digit}),
                  slu_pkg::OP_SEMI, 4'd0, st.tok_total, 1'b0);
               n = n + 2'd1;
               res[n] = slu_pkg::make_result(slu_pkg::KIND_END, 8'd0, slu_pkg::OP_SEMI, 4'd0,
                                             st.tok_total, 1'b0);
               n = n + 2'd1;
               st.tok_total = st.tok_total + 7'd1;
            end
            slu_pkg::MODE_BAR: begin
               res[n] = slu_pkg::make_result(slu_pkg::KIND_OP, 8'd0, slu_pkg::OP_PIPE, 4'd0,
                                             st.tok_total, 1'b0);
               n = n + 2'd1;
               st.tok_total = st.tok_total + 7'd1;
            end
            default: begin
            end
         endcase
         res[n] = slu_pkg::make_result(slu_pkg::KIND_SCRIPT, 8'd0, slu_pkg::OP_SEMI, 4'd0,
                                       st.tok_total, st.dropped);
         n = n + 2'd1;
         st = STATE_RESET;
      end else begin
         case (st.mode)
            slu_pkg::MODE_WORD: begin
               run_word = 1'b1;
            end
            slu_pkg::MODE_QUOTE: begin
               if (in_char == (st.quote_dbl ? slu_pkg::CH_DQUOTE : slu_pkg::CH_SQUOTE)) begin
                  st.mode = slu_pkg::MODE_WORD;
               end else begin
                  res[n] = slu_pkg::make_result(slu_pkg::KIND_CHAR, in_char, slu_pkg::OP_SEMI,
                                                4'd0, st.tok_total, 1'b0);
                  n = n + 2'd1;
               end
            end
            slu_pkg::MODE_ESCAPE: begin
               res[n] = slu_pkg::make_result(slu_pkg::KIND_CHAR, in_char, slu_pkg::OP_SEMI,
                                             4'd0, st.tok_total, 1'b0);
               n = n + 2'd1;
               st.mode = slu_pkg::MODE_WORD;
            end
            slu_pkg::MODE_AMP: begin
               if (in_char == slu_pkg::CH_AMP) begin
                  res[n] = slu_pkg::make_result(slu_pkg::KIND_OP, 8'd0, slu_pkg::OP_AND, 4'd0,
                                                st.tok_total, 1'b0);
                  n = n + 2'd1;
                  st.tok_total = st.tok_total + 7'd1;
                  st.mode = slu_pkg::MODE_IDLE;
               end else begin
                  res[n] = slu_pkg::make_result(slu_pkg::KIND_CHAR, slu_pkg::CH_AMP,
                                                slu_pkg::OP_SEMI, 4'd0, st.tok_total, 1'b0);
                  n = n + 2'd1;
                  st.mode = slu_pkg::MODE_WORD;
                  run_word = 1'b1;
               end
            end
            slu_pkg::MODE_BAR: begin
               if (in_char == slu_pkg::CH_BAR) begin
                  res[n] = slu_pkg::make_result(slu_pkg::KIND_OP, 8'd0, slu_pkg::OP_OR, 4'd0,
                                                st.tok_total, 1'b0);
                  n = n + 2'd1;
                  st.tok_total = st.tok_total + 7'd1;
                  st.mode = slu_pkg::MODE_IDLE;
               end else begin
                  res[n] = slu_pkg::make_result(slu_pkg::KIND_OP, 8'd0, slu_pkg::OP_PIPE, 4'd0,
                                                st.tok_total, 1'b0);
                  n = n + 2'd1;
                  st.tok_total = st.tok_total + 7'd1;
                  st.mode = slu_pkg::MODE_IDLE;
                  run_idle = 1'b1;
               end
            end
            slu_pkg::MODE_DIGIT: begin
               if (in_char == slu_pkg::CH_GT) begin
                  res[n] = slu_pkg::make_result(slu_pkg::KIND_OP, 8'd0, slu_pkg::OP_FD_OUT,
                                                st.digit, st.tok_total, 1'b0);
                  n = n + 2'd1;
                  st.tok_total = st.tok_total + 7'd1;
                  st.mode = slu_pkg::MODE_IDLE;
               end else begin
                  res[n] = slu_pkg::make_result(slu_pkg::KIND_CHAR,
                                                slu_pkg::CH_ZERO + {4'd0, st.digit},
                                                slu_pkg::OP_SEMI, 4'd0, st.tok_total, 1'b0);
                  n = n + 2'd1;
                  st.mode = slu_pkg::MODE_WORD;
                  run_word = 1'b1;
               end
            end
            default: begin
               run_idle = 1'b1;
            end
         endcase

         // byte inside a word
         if (run_word) begin
            if (slu_pkg::is_ws(in_char) || in_char == slu_pkg::CH_SEMI ||
                in_char == slu_pkg::CH_BAR || in_char == slu_pkg::CH_LT ||
                in_char == slu_pkg::CH_GT) begin
               res[n] = slu_pkg::make_result(slu_pkg::KIND_END, 8'd0, slu_pkg::OP_SEMI, 4'd0,
                                             st.tok_total, 1'b0);
               n = n + 2'd1;
               st.tok_total = st.tok_total + 7'd1;
               st.mode = slu_pkg::MODE_IDLE;
               run_idle = !slu_pkg::is_ws(in_char);
            end else begin
               run_plain = 1'b1;
            end
         end

         // byte between tokens
         if (run_idle) begin
            st.mode = slu_pkg::MODE_IDLE;
            if (!(({1'b0, st.tok_total} + 8'd1) < slu_pkg::TOKEN_LIMIT)) begin
               if (!slu_pkg::is_ws(in_char)) begin
                  st.dropped = 1'b1;
               end
            end else if (slu_pkg::is_ws(in_char)) begin
               st.mode = slu_pkg::MODE_IDLE;
            end else if (in_char == slu_pkg::CH_AMP) begin
               st.mode = slu_pkg::MODE_AMP;
            end else if (in_char == slu_pkg::CH_BAR) begin
               st.mode = slu_pkg::MODE_BAR;
            end else if (in_char >= slu_pkg::CH_ZERO && in_char <= slu_pkg::CH_NINE) begin
               st.digit = 4'(in_char - slu_pkg::CH_ZERO);
               st.mode  = slu_pkg::MODE_DIGIT;
            end else if (in_char == slu_pkg::CH_SEMI || in_char == slu_pkg::CH_LT ||
                         in_char == slu_pkg::CH_GT) begin
               res[n] = slu_pkg::make_result(slu_pkg::KIND_OP, 8'd0,
                  (in_char == slu_pkg::CH_SEMI) ? slu_pkg::OP_SEMI :
                  (in_char == slu_pkg::CH_LT) ? slu_pkg::OP_IN : slu_pkg::OP_OUT,
                  4'd0, st.tok_total, 1'b0);
               n = n + 2'd1;
               st.tok_total = st.tok_total + 7'd1;
            end else begin
               run_plain = 1'b1;
            end
         end

         // ordinary word byte: quote, escape or literal character
         if (run_plain) begin
            st.mode = slu_pkg::MODE_WORD;
            if (in_char == slu_pkg::CH_SQUOTE || in_char == slu_pkg::CH_DQUOTE) begin
               st.quote_dbl = (in_char == slu_pkg::CH_DQUOTE);
               st.mode      = slu_pkg::MODE_QUOTE;
            end else if (in_char == slu_pkg::CH_BSLASH) begin
               st.mode = slu_pkg::MODE_ESCAPE;
            end else begin
               res[n] = slu_pkg::make_result(slu_pkg::KIND_CHAR, in_char, slu_pkg::OP_SEMI,
                                             4'd0, st.tok_total, 1'b0);
               n = n + 2'd1;
            end
         end
      end

      state_in = accept ? st : state_ff;
   end

   always_comb begin
      push_valid     = accept && (n != 2'd0);
      push_run.count = n;
      for (int i = 0; i < slu_pkg::MAX_RESULTS; i++) begin
         push_run.res[i] = res[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/slu_queue.sv -----
`default_nettype none

module slu_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire slu_pkg::run_type push_run,
   input  wire logic             pop,
   output logic                  full,
   output logic                  empty,
   output slu_pkg::run_type      head_run
);

   slu_pkg::run_type               entry_ff [slu_pkg::QUEUE_DEPTH];
   logic [slu_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [slu_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [slu_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                           do_push, do_pop;

   assign full     = (count_ff == slu_pkg::QCNT_W'(slu_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_run = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_run;
      end
   end

endmodule

`default_nettype wire

// ----- design/slu_back.sv -----
`default_nettype none

module slu_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire slu_pkg::run_type head_run,
   output logic                  pop,
   slu_rsp_if.source             rsp
);

   logic [1:0]           idx_ff, idx_in;
   logic                 last;
   logic                 fire;
   slu_pkg::result_type  cur;

   assign cur  = head_run.res[idx_ff];
   assign last = (idx_ff == head_run.count - 2'd1);
   assign fire = rsp.valid && rsp.ready;
   assign pop  = fire && last;

   assign rsp.valid       = head_valid;
   assign rsp.result_kind = cur.kind;
   assign rsp.char_out    = cur.char_out;
   assign rsp.op_code     = cur.op;
   assign rsp.redirect_fd = cur.fd;
   assign rsp.token_index = cur.index;
   assign rsp.truncated   = cur.truncated;
   assign rsp.last_of_run = last;

   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire
